### hdl/rlp_pkg.sv
package rlp_pkg;

	localparam int CharW  = 8;
	localparam int ValueW = 32;
	localparam int RadixW = 5;
	localparam int DigitW = 5;

	localparam logic [RadixW-1:0] RADIX_BIN = RadixW'(2);
	localparam logic [RadixW-1:0] RADIX_OCT = RadixW'(8);
	localparam logic [RadixW-1:0] RADIX_DEC = RadixW'(10);
	localparam logic [RadixW-1:0] RADIX_HEX = RadixW'(16);

	localparam logic [DigitW-1:0] NOT_HEX = DigitW'(16);

	localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
	localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CH_X     = 8'h58;
	localparam logic [CharW-1:0] CH_O     = 8'h4F;
	localparam logic [CharW-1:0] CH_B     = 8'h42;
	localparam logic [CharW-1:0] CH_K     = 8'h4B;
	localparam logic [CharW-1:0] CH_M     = 8'h4D;
	localparam logic [CharW-1:0] CH_G     = 8'h47;

	localparam int ShiftK = 10;
	localparam int ShiftM = 20;
	localparam int ShiftG = 30;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_SIGNED = 4'b0010,
		PH_PREFIX = 4'b0100,
		PH_DIGITS = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [RadixW-1:0]   radix;
		logic                negative;
		logic [ValueW-1:0]   acc;
	} parse_state_t;

	function automatic logic [CharW-1:0] upcase(input logic [CharW-1:0] c);
		logic [CharW-1:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

	function automatic logic [DigitW-1:0] hex_value(input logic [CharW-1:0] c);
		logic [DigitW-1:0] r;
		r = NOT_HEX;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = DigitW'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = DigitW'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = DigitW'(c - 8'h61 + 8'd10);
		end
		return r;
	endfunction

endpackage

### hdl/rlp_char_if.sv
interface rlp_char_if
	import rlp_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] ch;
	logic             start_req;

	modport source (output valid, output ch, output start_req, input ready);
	modport sink (input valid, input ch, input start_req, output ready);
endinterface

### hdl/rlp_value_if.sv
interface rlp_value_if
	import rlp_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [ValueW-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

### hdl/radix_literal_parser.sv
// Character stream in, one value out per literal.
// The character ending a literal passes the input register, then its value is registered
// at the output. One character per cycle unless a literal ends while the output is full.
// The output register lets the next character in while a value waits to be taken.
// Reset (arst_n low): parser idle until a flagged start, base ten, no value pending.
module radix_literal_parser
	import rlp_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	rlp_char_if.sink       chars,
	rlp_value_if.source    results
);

	logic             valid_s1;
	logic [CharW-1:0] ch_s1;
	logic             start_s1;

	parse_state_t      state_q;
	parse_state_t      state_nxt;
	logic              emit;
	logic [ValueW-1:0] step_value;

	logic              out_valid_q;
	logic [ValueW-1:0] value_q;

	logic              s1_go;
	logic              out_free;

	assign out_free     = !out_valid_q || results.ready;
	assign s1_go        = valid_s1 && (!emit || out_free);
	assign chars.ready  = !valid_s1 || s1_go;
	assign results.valid = out_valid_q;
	assign results.value = signed'(value_q);

	rlp_step u_step (
		.cur       (state_q),
		.ch        (ch_s1),
		.start_req (start_s1),
		.nxt       (state_nxt),
		.emit      (emit),
		.value     (step_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1    <= chars.ch;
			start_s1 <= chars.start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= PH_IDLE;
			state_q.radix    <= RADIX_DEC;
			state_q.negative <= 1'b0;
			state_q.acc      <= '0;
		end else if (s1_go) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			value_q <= step_value;
		end
	end

endmodule

### hdl/rlp_step.sv
module rlp_step
	import rlp_pkg::*;
(
	input  parse_state_t      cur,
	input  logic [CharW-1:0]  ch,
	input  logic              start_req,
	output parse_state_t      nxt,
	output logic              emit,
	output logic [ValueW-1:0] value
);

	logic [CharW-1:0]  u;
	logic [DigitW-1:0] d;
	logic [ValueW-1:0] a;
	logic [ValueW-1:0] a_mul;
	logic [ValueW-1:0] v;
	logic [RadixW-1:0] r;
	logic              n;
	logic              active;
	logic              is_minus;
	logic              at_signed;
	logic              is_zero;
	logic              at_prefix;
	logic              pfx_hit;
	logic              digit_path;

	always_comb begin
		u = upcase(ch);
		d = hex_value(ch);
		a = start_req ? '0 : cur.acc;
		r = start_req ? RADIX_DEC : cur.radix;
		n = start_req ? 1'b0 : cur.negative;

		active    = start_req || (cur.phase != PH_IDLE);
		is_minus  = start_req && (ch == CH_MINUS);
		at_signed = (start_req && !is_minus) || (!start_req && cur.phase == PH_SIGNED);
		is_zero   = at_signed && (ch == CH_ZERO);
		at_prefix = !start_req && (cur.phase == PH_PREFIX);
		pfx_hit   = at_prefix && (u == CH_X || u == CH_O || u == CH_B);
		digit_path = active && !is_minus && !is_zero && !pfx_hit;

		case (r)
			RADIX_BIN: a_mul = a << 1;
			RADIX_OCT: a_mul = a << 3;
			RADIX_HEX: a_mul = a << 4;
			default:   a_mul = (a << 3) + (a << 1);
		endcase

		v = a;
		if (d == NOT_HEX) begin
			if (u == CH_K) begin
				v = a << ShiftK;
			end else if (u == CH_M) begin
				v = a << ShiftM;
			end else if (u == CH_G) begin
				v = a << ShiftG;
			end
		end
		value = n ? (ValueW'(0) - v) : v;

		nxt          = cur;
		nxt.acc      = a;
		nxt.radix    = r;
		nxt.negative = n;
		emit         = 1'b0;
		if (!active) begin
			nxt = cur;
		end else if (is_minus) begin
			nxt.negative = 1'b1;
			nxt.phase    = PH_SIGNED;
		end else if (is_zero) begin
			nxt.radix = RADIX_OCT;
			nxt.phase = PH_PREFIX;
		end else if (pfx_hit) begin
			nxt.phase = PH_DIGITS;
			if (u == CH_X) begin
				nxt.radix = RADIX_HEX;
			end else if (u == CH_O) begin
				nxt.radix = RADIX_OCT;
			end else begin
				nxt.radix = RADIX_BIN;
			end
		end else if (digit_path && (d < r)) begin
			nxt.acc   = a_mul + ValueW'(d);
			nxt.phase = PH_DIGITS;
		end else begin
			nxt.phase = PH_IDLE;
			emit      = 1'b1;
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import rlp_pkg::*;

	localparam int QuietLimit = 4000;
	localparam int MaxReports = 10;

	logic clk;
	logic arst_n;

	rlp_char_if  c_if ();
	rlp_value_if r_if ();

	radix_literal_parser DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (c_if),
		.results (r_if)
	);

	// parser state as predicted
	phase_t            prs_phase;
	logic [RadixW-1:0] prs_radix;
	logic              prs_neg;
	logic [ValueW-1:0] prs_acc;

	logic [ValueW-1:0] expected_values[$];

	int gap_pct;
	int stall_pct;
	int hold_req;
	int hold_left;
	int parsed_chars;
	int bad_count;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [CharW-1:0] fold_upper(logic [CharW-1:0] c);
		if (c >= 8'h61 && c <= 8'h7A) begin
			return c - 8'h20;
		end
		return c;
	endfunction

	function automatic logic [DigitW-1:0] char_digit(logic [CharW-1:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return DigitW'(c - 8'h30);
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			return DigitW'(c - 8'h41 + 8'd10);
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			return DigitW'(c - 8'h61 + 8'd10);
		end
		return NOT_HEX;
	endfunction

	// returns 1 when the character was ignored
	function automatic bit parse_char(logic [CharW-1:0] c, logic st);
		phase_t            lvl;
		logic [DigitW-1:0] d;
		logic [CharW-1:0]  u;
		logic [ValueW-1:0] v;
		if (st) begin
			prs_acc   = '0;
			prs_radix = RADIX_DEC;
			prs_neg   = 1'b0;
			if (c == CH_MINUS) begin
				prs_neg   = 1'b1;
				prs_phase = PH_SIGNED;
				return 1'b0;
			end
			lvl = PH_SIGNED;
		end else begin
			if (prs_phase == PH_IDLE) begin
				return 1'b1;
			end
			lvl = prs_phase;
		end
		if (lvl == PH_SIGNED) begin
			if (c == CH_ZERO) begin
				prs_radix = RADIX_OCT;
				prs_phase = PH_PREFIX;
				return 1'b0;
			end
			lvl = PH_DIGITS;
		end
		if (lvl == PH_PREFIX) begin
			u = fold_upper(c);
			prs_phase = PH_DIGITS;
			if (u == CH_X) begin
				prs_radix = RADIX_HEX;
				return 1'b0;
			end
			if (u == CH_O) begin
				prs_radix = RADIX_OCT;
				return 1'b0;
			end
			if (u == CH_B) begin
				prs_radix = RADIX_BIN;
				return 1'b0;
			end
		end
		d = char_digit(c);
		if (d < prs_radix) begin
			prs_acc   = prs_acc * ValueW'(prs_radix) + ValueW'(d);
			prs_phase = PH_DIGITS;
			return 1'b0;
		end
		v = prs_acc;
		if (d == NOT_HEX) begin
			u = fold_upper(c);
			if (u == CH_K) begin
				v = v << ShiftK;
			end else if (u == CH_M) begin
				v = v << ShiftM;
			end else if (u == CH_G) begin
				v = v << ShiftG;
			end
		end
		if (prs_neg) begin
			v = -v;
		end
		expected_values.push_back(v);
		prs_phase = PH_IDLE;
		return 1'b0;
	endfunction

	task automatic send_char(logic [CharW-1:0] c, logic st);
		while ($urandom_range(99) < gap_pct) begin
			c_if.valid <= 1'b0;
			@(posedge clk);
		end
		c_if.valid     <= 1'b1;
		c_if.ch        <= c;
		c_if.start_req <= st;
		@(posedge clk);
		while (!c_if.ready) begin
			@(posedge clk);
		end
		if (!parse_char(c, st)) begin
			parsed_chars++;
		end
	endtask

	task automatic send_str(string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], i == 0);
		end
	endtask

	function automatic logic [CharW-1:0] any_case(logic [CharW-1:0] c);
		return $urandom_range(1) ? (c | 8'h20) : c;
	endfunction

	function automatic logic [CharW-1:0] digit_char(int unsigned dv);
		if (dv < 10) begin
			return CH_ZERO + CharW'(dv);
		end
		return any_case(8'h41 + CharW'(dv - 10));
	endfunction

	function automatic logic [CharW-1:0] suffix_char();
		case ($urandom_range(2))
			0: return any_case(CH_K);
			1: return any_case(CH_M);
			default: return any_case(CH_G);
		endcase
	endfunction

	// one literal, sometimes cut short by the next start, sometimes with junk after it
	task automatic send_literal(int max_digits);
		logic [CharW-1:0]  txt[$];
		logic [RadixW-1:0] base;
		int                n;
		base = RADIX_DEC;
		if ($urandom_range(3) == 0) begin
			txt.push_back(CH_MINUS);
		end
		case ($urandom_range(6))
			0: begin
				txt.push_back(CH_ZERO);
				base = RADIX_OCT;
			end
			1: begin
				txt.push_back(CH_ZERO);
				txt.push_back(any_case(CH_X));
				base = RADIX_HEX;
			end
			2: begin
				txt.push_back(CH_ZERO);
				txt.push_back(any_case(CH_O));
				base = RADIX_OCT;
			end
			3: begin
				txt.push_back(CH_ZERO);
				txt.push_back(any_case(CH_B));
				base = RADIX_BIN;
			end
			default: ;
		endcase
		n = $urandom_range(max_digits);
		if (base == RADIX_BIN) begin
			n = n * 3;
		end
		for (int i = 0; i < n; i++) begin
			txt.push_back(digit_char($urandom_range(base - 1)));
		end
		case ($urandom_range(5))
			0, 1: txt.push_back(suffix_char());
			2: begin
				if (base != RADIX_HEX) begin
					txt.push_back(digit_char($urandom_range(15, base)));
				end else begin
					txt.push_back(8'h20);
				end
			end
			3: txt.push_back($urandom_range(1) ? 8'hFF : 8'h00);
			4: txt.push_back(8'h2C);
			default: txt.push_back(8'($urandom));
		endcase
		n = txt.size();
		if ($urandom_range(7) == 0) begin
			n = $urandom_range(txt.size());
		end
		for (int i = 0; i < n; i++) begin
			send_char(txt[i], i == 0);
		end
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(3, 1)) send_char(8'($urandom), 1'b0);
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(4, 1)) send_char(8'($urandom), 1'($urandom));
	endtask

	task automatic run_random(int items, int max_digits);
		int target;
		target = parsed_chars + items;
		while (parsed_chars < target) begin
			if ($urandom_range(9) == 0) begin
				send_noise();
			end else if ($urandom_range(19) == 0) begin
				send_literal(40);
			end else begin
				send_literal(max_digits);
			end
		end
	endtask

	task automatic test_directed();
		gap_pct   = 0;
		stall_pct = 0;
		send_str("-0b101k");
		send_str("0778");
		send_str("9c");
		send_str("0xM");
		send_str("0k");
		send_char(CH_MINUS, 1'b1);
		send_char(8'hFF, 1'b0);
		send_str("7");
		send_str("5g");
		send_str("0o7f");
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
	endtask

	task automatic test_no_idle();
		gap_pct   = 0;
		stall_pct = 0;
		run_random(400, 12);
	endtask

	task automatic test_sender_gaps();
		gap_pct   = 83;
		stall_pct = 0;
		run_random(400, 12);
	endtask

	task automatic test_receiver_stalls();
		gap_pct   = 0;
		stall_pct = 83;
		run_random(400, 12);
	endtask

	task automatic test_both_idle();
		gap_pct   = 24;
		stall_pct = 24;
		run_random(400, 12);
	endtask

	task automatic test_backpressure();
		gap_pct   = 0;
		stall_pct = 0;
		repeat (2) begin
			hold_req = 300;
			run_random(150, 2);
		end
	endtask

	initial begin
		r_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				r_if.ready <= 1'b0;
				hold_left--;
			end else begin
				r_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && r_if.valid && r_if.ready) begin
			if (expected_values.size() == 0) begin
				if (bad_count < MaxReports) begin
					$display("unexpected value %0d", r_if.value);
				end
				bad_count++;
			end else begin
				if (r_if.value !== expected_values[0]) begin
					if (bad_count < MaxReports) begin
						$display("value mismatch: expected %0d, got %0d",
							$signed(expected_values[0]), r_if.value);
					end
					bad_count++;
				end
				void'(expected_values.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((c_if.valid && c_if.ready) || (r_if.valid && r_if.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QuietLimit) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		c_if.valid     <= 1'b0;
		c_if.ch        <= '0;
		c_if.start_req <= 1'b0;
		prs_phase      = PH_IDLE;
		prs_radix      = RADIX_DEC;
		prs_neg        = 1'b0;
		prs_acc        = '0;
		gap_pct        = 0;
		stall_pct      = 0;
		hold_req       = 0;
		hold_left      = 0;
		parsed_chars   = 0;
		bad_count      = 0;
		quiet_cycles   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_no_idle();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();

		c_if.valid <= 1'b0;
		while (expected_values.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (bad_count == 0 && expected_values.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
